// ===== hdl/rama_pkg.sv =====
`default_nettype none

package rama_pkg;

  // Data word width of every numerator and denominator.
  localparam int W  = 32;
  // Width of the bit counter and of the common power-of-two count.
  localparam int CW = $clog2(W);

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_MUL = 1'b1;

  typedef struct packed {
    logic                op;
    logic signed [W-1:0] a_num;
    logic        [W-1:0] a_den;
    logic signed [W-1:0] b_num;
    logic        [W-1:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [W-1:0] res_num;
    logic        [W-1:0] res_den;
    logic                error;
  } out_word_t;

  // Request to the shared adder: a + b, or a - b when sub is set.
  typedef struct packed {
    logic         sub;
    logic [W:0]   a;
    logic [W:0]   b;
  } alu_req_t;

  // Sum and carry out; for a subtract, carry high means no borrow.
  typedef struct packed {
    logic [W:0]   sum;
    logic         carry;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_NEG,
    S_GCD_TWO,
    S_GCD,
    S_SHL,
    S_DIV1,
    S_DIV2,
    S_SIGN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/rational_add_multiply_reduce.sv =====
`default_nettype none

// Rational add / multiply with reduction to lowest terms. Each input word
// carries two fractions (signed numerator, unsigned denominator) and an op:
// add gives (a_num*b_den + b_num*a_den)/(a_den*b_den), multiply gives
// (a_num*b_num)/(a_den*b_den); all products and sums wrap at the word width.
// The result is divided by the greatest common divisor of the numerator's
// magnitude and the denominator, so a zero numerator yields 0/1 and a zero
// denominator yields +1/0 or -1/0. When both are zero the result word is 0/0
// with error set. All arithmetic runs on one shared adder under a sequencer,
// one item at a time: the products are formed by shift-and-add (two for
// multiply, three for add), a common power of two is stripped and restored
// one bit per cycle each way, the binary GCD does one halving, swap or
// subtract per cycle (skipped when the numerator or denominator is zero),
// and the two quotients are formed by restoring division. An error word
// skips the reduction. in_stall is high from the cycle after acceptance
// until the result is loaded into the output register; loading waits while
// a stalled result still occupies that register. A waiting result does not
// block the next word's computation.
module rational_add_multiply_reduce (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rama_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output rama_pkg::out_word_t out_word
);

  localparam int W  = rama_pkg::W;
  localparam int CW = rama_pkg::CW;

  rama_pkg::state_t    state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  rama_pkg::out_word_t out_word_r, out_word_nxt;

  // Latched operands; a_num goes straight into the multiplier.
  logic          op_r, op_nxt;
  logic [W-1:0]  ad_r, ad_nxt;
  logic [W-1:0]  bn_r, bn_nxt;
  logic [W-1:0]  bd_r, bd_nxt;

  // Shift-and-add multiplier.
  logic [W-1:0]  mx_r, mx_nxt;
  logic [W-1:0]  my_r, my_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Wrapped fraction, then reduced result.
  logic [W-1:0]  num_r, num_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic [W-1:0]  mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic          err_r, err_nxt;

  // Binary GCD; v_r ends up holding the divisor.
  logic [W-1:0]  u_r, u_nxt;
  logic [W-1:0]  v_r, v_nxt;
  logic [CW-1:0] k_r, k_nxt;

  // Restoring divider.
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dq_r, dq_nxt;
  logic [W-1:0]  q_r, q_nxt;

  rama_pkg::alu_req_t alu_req;
  rama_pkg::alu_rsp_t alu_rsp;

  logic          last;
  logic          u_zero;
  logic          v_zero;
  logic          out_free;
  logic [W-1:0]  acc_step;
  logic [W:0]    div_shift;
  logic [W-1:0]  div_rem;
  logic [W-1:0]  div_quo;

  rama_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign last     = (cnt_r == CW'(W - 1));
  assign u_zero   = (u_r == '0);
  assign v_zero   = (v_r == '0);
  assign out_free = !out_valid_r || !out_stall;

  assign acc_step  = my_r[0] ? alu_rsp.sum[W-1:0] : acc_r;
  assign div_shift = {rem_r, dq_r[W-1]};
  assign div_rem   = alu_rsp.carry ? alu_rsp.sum[W-1:0] : div_shift[W-1:0];
  assign div_quo   = {dq_r[W-2:0], alu_rsp.carry};

  assign in_stall  = (state_r != rama_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rama_pkg::S_IDLE: begin
        if (in_valid) state_nxt = rama_pkg::S_MUL1;
      end
      rama_pkg::S_MUL1: begin
        if (last) begin
          state_nxt = (op_r == rama_pkg::OP_ADD) ? rama_pkg::S_MUL2 : rama_pkg::S_MUL3;
        end
      end
      rama_pkg::S_MUL2: begin
        if (last) state_nxt = rama_pkg::S_MUL3;
      end
      rama_pkg::S_MUL3: begin
        if (last) state_nxt = rama_pkg::S_NEG;
      end
      rama_pkg::S_NEG: begin
        state_nxt = rama_pkg::S_GCD_TWO;
      end
      rama_pkg::S_GCD_TWO: begin
        if (u_zero && v_zero) begin
          state_nxt = rama_pkg::S_DONE;
        end else if (u_zero || v_zero) begin
          state_nxt = rama_pkg::S_DIV1;
        end else if (u_r[0] || v_r[0]) begin
          state_nxt = rama_pkg::S_GCD;
        end
      end
      rama_pkg::S_GCD: begin
        if (u_zero) state_nxt = rama_pkg::S_SHL;
      end
      rama_pkg::S_SHL: begin
        if (k_r == '0) state_nxt = rama_pkg::S_DIV1;
      end
      rama_pkg::S_DIV1: begin
        if (last) state_nxt = rama_pkg::S_DIV2;
      end
      rama_pkg::S_DIV2: begin
        if (last) state_nxt = rama_pkg::S_SIGN;
      end
      rama_pkg::S_SIGN: begin
        state_nxt = rama_pkg::S_DONE;
      end
      rama_pkg::S_DONE: begin
        if (out_free) state_nxt = rama_pkg::S_IDLE;
      end
      default: begin
        state_nxt = rama_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer: datapath control and shared adder requests.
  always_comb begin
    op_nxt        = op_r;
    ad_nxt        = ad_r;
    bn_nxt        = bn_r;
    bd_nxt        = bd_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    err_nxt       = err_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    q_nxt         = q_r;
    out_word_nxt  = out_word_r;
    // Drop the output word once it is taken.
    out_valid_nxt = out_valid_r && out_stall;
    alu_req       = '0;

    case (state_r)
      rama_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_word.op;
          ad_nxt  = in_word.a_den;
          bn_nxt  = in_word.b_num;
          bd_nxt  = in_word.b_den;
          // First product: a_num*b_num for multiply, a_num*b_den for add.
          mx_nxt  = in_word.a_num;
          my_nxt  = (in_word.op == rama_pkg::OP_MUL) ? in_word.b_num : in_word.b_den;
          acc_nxt = '0;
          cnt_nxt = '0;
          err_nxt = 1'b0;
        end
      end

      rama_pkg::S_MUL1, rama_pkg::S_MUL2, rama_pkg::S_MUL3: begin
        // One partial product per cycle; bits above W fall off.
        alu_req.a = {1'b0, acc_r};
        alu_req.b = {1'b0, mx_r};
        acc_nxt   = acc_step;
        mx_nxt    = mx_r << 1;
        my_nxt    = my_r >> 1;
        cnt_nxt   = cnt_r + 1'b1;
        if (last) begin
          cnt_nxt = '0;
          if (state_r == rama_pkg::S_MUL3) begin
            den_nxt = acc_step;
          end else if (state_r == rama_pkg::S_MUL1 && op_r == rama_pkg::OP_ADD) begin
            // Keep the sum running into b_num*a_den.
            mx_nxt = bn_r;
            my_nxt = ad_r;
          end else begin
            num_nxt = acc_step;
            mx_nxt  = ad_r;
            my_nxt  = bd_r;
            acc_nxt = '0;
          end
        end
      end

      rama_pkg::S_NEG: begin
        alu_req.sub = 1'b1;
        alu_req.b   = {1'b0, num_r};
        neg_nxt     = num_r[W-1];
        mag_nxt     = num_r[W-1] ? alu_rsp.sum[W-1:0] : num_r;
        u_nxt       = num_r[W-1] ? alu_rsp.sum[W-1:0] : num_r;
        v_nxt       = den_r;
        k_nxt       = '0;
      end

      rama_pkg::S_GCD_TWO: begin
        if (u_zero && v_zero) begin
          err_nxt = 1'b1;
        end else if (u_zero || v_zero) begin
          // GCD is the nonzero one; move it into the divisor slot.
          if (v_zero) v_nxt = u_r;
          dq_nxt  = mag_r;
          rem_nxt = '0;
          cnt_nxt = '0;
        end else if (!u_r[0] && !v_r[0]) begin
          // Strip the common power of two.
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 1'b1;
        end
      end

      rama_pkg::S_GCD: begin
        if (!u_zero) begin
          if (!u_r[0]) begin
            u_nxt = u_r >> 1;
          end else if (!v_r[0]) begin
            v_nxt = v_r >> 1;
          end else begin
            alu_req.sub = 1'b1;
            alu_req.a   = {1'b0, u_r};
            alu_req.b   = {1'b0, v_r};
            if (alu_rsp.carry) begin
              u_nxt = alu_rsp.sum[W-1:0] >> 1;
            end else begin
              // Swap so that the larger one is subtracted from next time.
              u_nxt = v_r;
              v_nxt = u_r;
            end
          end
        end
      end

      rama_pkg::S_SHL: begin
        // Restore the common power of two, one bit a cycle.
        if (k_r == '0) begin
          dq_nxt  = mag_r;
          rem_nxt = '0;
          cnt_nxt = '0;
        end else begin
          v_nxt = v_r << 1;
          k_nxt = k_r - 1'b1;
        end
      end

      rama_pkg::S_DIV1, rama_pkg::S_DIV2: begin
        // One quotient bit per cycle: trial subtract, restore on borrow.
        alu_req.sub = 1'b1;
        alu_req.a   = div_shift;
        alu_req.b   = {1'b0, v_r};
        rem_nxt     = div_rem;
        dq_nxt      = div_quo;
        cnt_nxt     = cnt_r + 1'b1;
        if (last) begin
          cnt_nxt = '0;
          if (state_r == rama_pkg::S_DIV1) begin
            q_nxt   = div_quo;
            dq_nxt  = den_r;
            rem_nxt = '0;
          end else begin
            den_nxt = div_quo;
          end
        end
      end

      rama_pkg::S_SIGN: begin
        alu_req.sub = 1'b1;
        alu_req.b   = {1'b0, q_r};
        q_nxt       = neg_r ? alu_rsp.sum[W-1:0] : q_r;
      end

      rama_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            out_word_nxt.res_num = '0;
            out_word_nxt.res_den = '0;
            out_word_nxt.error   = 1'b1;
          end else begin
            out_word_nxt.res_num = q_r;
            out_word_nxt.res_den = den_r;
            out_word_nxt.error   = 1'b0;
          end
        end
      end

      default: begin
        alu_req = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rama_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    ad_r       <= ad_nxt;
    bn_r       <= bn_nxt;
    bd_r       <= bd_nxt;
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    err_r      <= err_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    k_r        <= k_nxt;
    rem_r      <= rem_nxt;
    dq_r       <= dq_nxt;
    q_r        <= q_nxt;
    out_word_r <= out_word_nxt;
  end

  // An error word always carries 0/0.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.error) |-> (out_word.res_num == '0 && out_word.res_den == '0))
    else $error("error word with nonzero fraction");

  // Busy right after a word is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // The divisor is never zero while dividing or reducing.
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rama_pkg::S_DIV1 || state_r == rama_pkg::S_DIV2 ||
     state_r == rama_pkg::S_GCD) |-> (v_r != '0))
    else $error("zero divisor in reduction");

endmodule

`default_nettype wire

// ===== hdl/rama_alu.sv =====
`default_nettype none

module rama_alu (
  input  rama_pkg::alu_req_t req,
  output rama_pkg::alu_rsp_t rsp
);

  localparam int W = rama_pkg::W;

  logic [W:0]   b_eff;
  logic [W+1:0] full;

  // Subtract as add of the inverted operand plus one.
  assign b_eff = req.sub ? ~req.b : req.b;
  assign full  = {1'b0, req.a} + {1'b0, b_eff} + {{(W+1){1'b0}}, req.sub};

  assign rsp.sum   = full[W:0];
  assign rsp.carry = full[W+1];

endmodule

`default_nettype wire

// ===== dv/rational_add_multiply_reduce_test.sv =====
module rational_add_multiply_reduce_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = rama_pkg::W;

  // Handy corner values at the word width.
  localparam logic [W-1:0] MOST_NEG  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ALL_ONES  = {W{1'b1}};
  // Two of these multiplied wrap to zero: used to force a zero denominator.
  localparam logic [W-1:0] HALF_WRAP = {{(W/2-1){1'b0}}, 1'b1, {(W/2){1'b0}}};
  localparam int RANDOM_WORDS = 560;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  rama_pkg::in_word_t  in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rama_pkg::out_word_t out_word;

  // Set while both sides run flat out, with no idle cycles at all.
  bit        quiet = 1'b0;

  rama_pkg::out_word_t expected_fractions[$];
  rama_pkg::out_word_t oldest_fraction;
  int        mismatch_count = 0;
  int        result_index   = 0;

  rational_add_multiply_reduce dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #1 clk = ~clk;

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

  // Compute the wrapped cross products, then divide both terms by the
  // Euclidean GCD of the numerator magnitude and the denominator. The sign
  // is stripped before the divide and put back after, so the most negative
  // numerator keeps its mathematical sign.
  function automatic rama_pkg::out_word_t reduce_fraction(rama_pkg::in_word_t w);
    logic [W-1:0]        num;
    logic [W-1:0]        den;
    logic [W-1:0]        mag;
    logic [W-1:0]        x;
    logic [W-1:0]        y;
    logic [W-1:0]        r;
    logic [W-1:0]        q;
    logic                neg;
    rama_pkg::out_word_t o;
    den = w.a_den * w.b_den;
    if (w.op == rama_pkg::OP_MUL) begin
      num = w.a_num * w.b_num;
    end else begin
      num = w.a_num * w.b_den + w.b_num * w.a_den;
    end
    neg = num[W-1];
    mag = neg ? -num : num;
    x = mag;
    y = den;
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    // GCD of zero and zero: no valid fraction, flag it with 0/0.
    if (x == '0) begin
      o.res_num = '0;
      o.res_den = '0;
      o.error   = 1'b1;
    end else begin
      q = mag / x;
      o.res_num = neg ? -q : q;
      o.res_den = den / x;
      o.error   = 1'b0;
    end
    return o;
  endfunction

  // Scoreboard: check the result first, then log the new word, so a word and
  // a result accepted at the same edge never get paired with each other.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_fractions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result word %0d: %0d/%0d error %0b", result_index,
                   $signed(out_word.res_num), out_word.res_den, out_word.error);
        end
      end else begin
        oldest_fraction = expected_fractions.pop_front();
        if (out_word.res_num !== oldest_fraction.res_num ||
            out_word.res_den !== oldest_fraction.res_den ||
            out_word.error   !== oldest_fraction.error) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result word %0d: expected %0d/%0d error %0b, got %0d/%0d error %0b",
                     result_index, $signed(oldest_fraction.res_num),
                     oldest_fraction.res_den, oldest_fraction.error,
                     $signed(out_word.res_num), out_word.res_den, out_word.error);
          end
        end
      end
      result_index++;
    end
    if (rst_n && in_valid && !in_stall) begin
      expected_fractions.push_back(reduce_fraction(in_word));
    end
  end

  // Stall the result side now and then, except in the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 15);
  end

  // Present one word and hold it until accepted; then maybe idle a while.
  // Call only at a rising edge.
  task automatic send_fractions(logic op, logic [W-1:0] an, logic [W-1:0] ad,
                                logic [W-1:0] bn, logic [W-1:0] bd);
    rama_pkg::in_word_t w;
    w.op    = op;
    w.a_num = an;
    w.a_den = ad;
    w.b_num = bn;
    w.b_den = bd;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every logged word has produced its result.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_fractions.size() != 0) @(posedge clk);
  endtask

  // Numerator mix: full random, small values that reduce a lot, signed
  // powers of two, and the extremes.
  function automatic logic [W-1:0] pick_numerator(int unsigned kind);
    logic [W-1:0] v;
    case (kind)
      0: v = $urandom;
      1: v = $urandom_range(2000) - 1000;
      2: begin
        v = HALF_WRAP >> $urandom_range(W/2);
        v = v << $urandom_range(W/2);
        if ($urandom_range(1)) v = -v;
      end
      default: begin
        case ($urandom_range(4))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = ALL_ONES;
          3: v = '0;
          default: v = 1;
        endcase
      end
    endcase
    return v;
  endfunction

  // Denominators follow the same mix but are never zero.
  function automatic logic [W-1:0] pick_denominator(int unsigned kind);
    logic [W-1:0] v;
    case (kind)
      0: v = $urandom;
      1: v = $urandom_range(1000, 1);
      2: begin
        v = HALF_WRAP >> $urandom_range(W/2);
        v = v << $urandom_range(W/2);
      end
      default: begin
        case ($urandom_range(3))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = ALL_ONES;
          default: v = 1;
        endcase
      end
    endcase
    if (v == '0) v = 1;
    return v;
  endfunction

  // Field extremes and plain arithmetic through both operations.
  task automatic test_field_extremes();
    send_fractions(rama_pkg::OP_ADD, MOST_POS, 1, MOST_POS, 1);
    send_fractions(rama_pkg::OP_ADD, MOST_NEG, 1, MOST_NEG, 1);
    send_fractions(rama_pkg::OP_MUL, MOST_NEG, 1, MOST_NEG, 1);
    send_fractions(rama_pkg::OP_MUL, MOST_POS, ALL_ONES, MOST_POS, ALL_ONES);
    send_fractions(rama_pkg::OP_MUL, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_fractions(rama_pkg::OP_MUL, ALL_ONES, ALL_ONES, 1, 1);
    send_fractions(rama_pkg::OP_ADD, 1, 2, 1, 3);
    send_fractions(rama_pkg::OP_MUL, 2, 3, 3, 4);
    send_fractions(rama_pkg::OP_ADD, 1, 2, -1, 2);
    send_fractions(rama_pkg::OP_ADD, 0, 1, 0, 1);
  endtask

  // Error case, zero denominators (wrapped and given), most negative numerator.
  task automatic test_special_cases();
    // numerator and denominator both zero
    send_fractions(rama_pkg::OP_MUL, 0, HALF_WRAP, 5, HALF_WRAP);
    send_fractions(rama_pkg::OP_ADD, 0, HALF_WRAP, 0, HALF_WRAP);
    send_fractions(rama_pkg::OP_MUL, HALF_WRAP, HALF_WRAP, HALF_WRAP, HALF_WRAP);
    send_fractions(rama_pkg::OP_ADD, 0, 0, 0, 9);
    // denominator zero, numerator not: expect a signed one over zero
    send_fractions(rama_pkg::OP_ADD, 3, HALF_WRAP, 0, HALF_WRAP);
    send_fractions(rama_pkg::OP_MUL, -7, HALF_WRAP, 1, HALF_WRAP);
    send_fractions(rama_pkg::OP_MUL, 5, 0, 3, 7);
    send_fractions(rama_pkg::OP_ADD, -4, 0, 1, 1);
    // most negative numerator keeps its sign through the reduction
    send_fractions(rama_pkg::OP_MUL, MOST_NEG, 1, 1, MOST_NEG);
    send_fractions(rama_pkg::OP_MUL, MOST_NEG, 3, 1, 1);
    send_fractions(rama_pkg::OP_ADD, MOST_NEG, 1, 0, 1);
    send_fractions(rama_pkg::OP_ADD, MOST_NEG, 2, MOST_NEG, 2);
  endtask

  // Random words, with a stretch in the middle where neither side idles.
  task automatic test_random_words();
    int unsigned kind_a;
    int unsigned kind_b;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      quiet  = (i >= 200 && i < 320);
      kind_a = $urandom_range(99) < 40 ? 0 : $urandom_range(3);
      kind_b = $urandom_range(99) < 40 ? 0 : $urandom_range(3);
      send_fractions(1'($urandom_range(1)), pick_numerator(kind_a),
                     pick_denominator(kind_a),
                     pick_numerator(kind_b), pick_denominator(kind_b));
    end
    quiet = 1'b0;
  endtask

  // Let the block empty out completely, then restart with a fresh burst.
  task automatic test_drain_pause();
    for (int i = 0; i < 6; i++) begin
      send_fractions(1'($urandom_range(1)), pick_numerator(1), pick_denominator(1),
                     pick_numerator(0), pick_denominator(0));
      if (i == 2) wait_for_drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_special_cases();
    test_drain_pause();
    test_random_words();
    wait_for_drain();
    // Hold a little longer to catch any stray result.
    repeat (400) @(posedge clk);
    if (mismatch_count == 0 && expected_fractions.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
